@@ src/hed_pkg.sv @@
// Shared types and constants of the HTML entity decoder.
package hed_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SAT   = 21'h110000;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_OPEN, OP_POP, OP_APPEND, OP_PARSE_INIT, OP_K_INC, OP_K_DEC,
    OP_SIGN, OP_DIGIT, OP_PUSH_SEMI, OP_PUSH_PK, OP_K_LAST, OP_K_ZERO, OP_CLOSE, OP_FLUSH
  } op_e;

  typedef enum logic [2:0] {
    EM_HEAD, EM_AMP, EM_NAME, EM_UTF, EM_PK
  } emit_e;

  typedef struct packed {
    op_e        op;
    logic       emit;
    emit_e      emit_sel;
    logic [1:0] utf_idx;
  } cmd_t;

  typedef struct packed {
    logic       q_empty;
    logic       head_amp;
    logic       head_semi;
    logic       last;
    logic       pc_win;
    logic       name_hit;
    logic       num_ok;
    logic       k_lt_pc;
    logic       k_nx_lt_pc;
    logic       k_ge1;
    logic       hex;
    logic       cur_ws;
    logic       cur_plus;
    logic       cur_minus;
    logic       cur_zero;
    logic       cur_x;
    logic       cur_digit;
    logic       val_ok;
    logic [1:0] utf_last;
    logic       stage_v;
    logic       out_free;
  } sts_t;

endpackage

@@ src/hed_if.sv @@
// Stream interfaces of the HTML entity decoder.
interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface

@@ src/hed_dp.sv @@
// Datapath: work queue, entity buffer, numeric parser, UTF-8 encoder, output stage.
module hed_dp #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hed_pkg::cmd_t       cmd_i,
  output hed_pkg::sts_t       sts_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);

  localparam int unsigned DEPTH = WINDOW + 1;
  localparam int unsigned QD    = DEPTH + 1;
  localparam int unsigned PCW   = $clog2(DEPTH + 1);
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned QNW   = $clog2(QD + 1);
  localparam int unsigned CW    = hed_pkg::CP_W;

  logic [7:0]     q_q [QD];
  logic [7:0]     q_d [QD];
  logic [QNW-1:0] qn_q, qn_d;
  logic [7:0]     p_q [DEPTH];
  logic [PCW-1:0] pc_q, pc_d, k_q, k_d, len;
  logic [CW-1:0]  v_q, v_d;
  logic           neg_q, neg_d, hex_q, hex_d, last_q, last_d;
  logic [7:0]     stage_q;
  logic           stage_v_q, out_v_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;

  logic [7:0]     nm [4];
  logic [7:0]     head, cur, name_char, utf_byte, emit_byte, push_byte;
  logic           hit, do_push, do_pop, out_free;
  logic [3:0]     dval;
  logic           dvalid;
  logic [CW+4:0]  acc;
  logic [1:0]     utf_last;

  // fixed taps of the entity body for name matching
  for (genvar i = 0; i < 4; i++) begin : g_nm
    if (i + 1 < DEPTH) begin : g_on
      assign nm[i] = p_q[i+1];
    end else begin : g_off
      assign nm[i] = '0;
    end
  end

  assign head     = q_q[0];
  assign cur      = p_q[k_q[IW-1:0]];
  assign len      = pc_q - PCW'(1);
  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    hit       = 1'b1;
    name_char = hed_pkg::CH_AMP;
    if (len == PCW'(3) && nm[0] == 8'h61 && nm[1] == 8'h6D && nm[2] == 8'h70) begin
      name_char = hed_pkg::CH_AMP;
    end else if (len == PCW'(2) && nm[0] == 8'h6C && nm[1] == 8'h74) begin
      name_char = hed_pkg::CH_LT;
    end else if (len == PCW'(2) && nm[0] == 8'h67 && nm[1] == 8'h74) begin
      name_char = hed_pkg::CH_GT;
    end else if (len == PCW'(4) && nm[0] == 8'h71 && nm[1] == 8'h75 && nm[2] == 8'h6F
                 && nm[3] == 8'h74) begin
      name_char = hed_pkg::CH_QUOT;
    end else if ((len == PCW'(4) && nm[0] == 8'h61 && nm[1] == 8'h70 && nm[2] == 8'h6F
                  && nm[3] == 8'h73)
              || (len == PCW'(3) && nm[0] == hed_pkg::CH_HASH && nm[1] == 8'h33
                  && nm[2] == 8'h39)
              || (len == PCW'(4) && nm[0] == hed_pkg::CH_HASH && nm[1] == hed_pkg::CH_X
                  && nm[2] == 8'h32 && nm[3] == 8'h37)) begin
      name_char = hed_pkg::CH_APOS;
    end else if (len == PCW'(4) && nm[0] == 8'h6E && nm[1] == 8'h62 && nm[2] == 8'h73
                 && nm[3] == 8'h70) begin
      name_char = hed_pkg::CH_SPACE;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    dvalid = 1'b1;
    dval   = '0;
    if (cur >= 8'h30 && cur <= 8'h39) begin
      dval = 4'(cur - 8'h30);
    end else if (cur >= 8'h61 && cur <= 8'h66) begin
      dval = 4'(cur - 8'h57);
    end else if (cur >= 8'h41 && cur <= 8'h46) begin
      dval = 4'(cur - 8'h37);
    end else begin
      dvalid = 1'b0;
    end
  end

  assign acc = hex_q ? ({5'd0, v_q} << 4) + (CW+5)'(dval)
                     : ({5'd0, v_q} << 3) + ({5'd0, v_q} << 1) + (CW+5)'(dval);

  always_comb begin
    if (v_q < CW'(21'h80))         utf_last = 2'd0;
    else if (v_q < CW'(21'h800))   utf_last = 2'd1;
    else if (v_q < CW'(21'h10000)) utf_last = 2'd2;
    else                           utf_last = 2'd3;
  end

  always_comb begin
    utf_byte = {2'b10, v_q[5:0]};
    case (utf_last)
      2'd0: utf_byte = v_q[7:0];
      2'd1: if (cmd_i.utf_idx == 2'd0) utf_byte = {3'b110, v_q[10:6]};
      2'd2: begin
        if (cmd_i.utf_idx == 2'd0)      utf_byte = {4'b1110, v_q[15:12]};
        else if (cmd_i.utf_idx == 2'd1) utf_byte = {2'b10, v_q[11:6]};
      end
      2'd3: begin
        if (cmd_i.utf_idx == 2'd0)      utf_byte = {5'b11110, v_q[20:18]};
        else if (cmd_i.utf_idx == 2'd1) utf_byte = {2'b10, v_q[17:12]};
        else if (cmd_i.utf_idx == 2'd2) utf_byte = {2'b10, v_q[11:6]};
      end
      default: utf_byte = {2'b10, v_q[5:0]};
    endcase
  end

  always_comb begin
    case (cmd_i.emit_sel)
      hed_pkg::EM_HEAD: emit_byte = head;
      hed_pkg::EM_AMP:  emit_byte = hed_pkg::CH_AMP;
      hed_pkg::EM_NAME: emit_byte = name_char;
      hed_pkg::EM_UTF:  emit_byte = utf_byte;
      hed_pkg::EM_PK:   emit_byte = cur;
      default:          emit_byte = cur;
    endcase
  end

  always_comb begin
    qn_d      = qn_q;
    pc_d      = pc_q;
    k_d       = k_q;
    v_d       = v_q;
    neg_d     = neg_q;
    hex_d     = hex_q;
    last_d    = last_q;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    push_byte = hed_pkg::CH_SEMI;
    case (cmd_i.op)
      hed_pkg::OP_LOAD: begin
        qn_d   = QNW'(1);
        last_d = in_last_i;
      end
      hed_pkg::OP_OPEN: begin
        do_pop = 1'b1;
        pc_d   = PCW'(1);
      end
      hed_pkg::OP_POP: do_pop = 1'b1;
      hed_pkg::OP_APPEND: begin
        do_pop = 1'b1;
        pc_d   = pc_q + PCW'(1);
      end
      hed_pkg::OP_PARSE_INIT: begin
        v_d   = '0;
        neg_d = 1'b0;
        hex_d = (pc_q > PCW'(2)) && ((p_q[2] | hed_pkg::CASE_BIT) == hed_pkg::CH_X);
        k_d   = hex_d ? PCW'(3) : PCW'(2);
      end
      hed_pkg::OP_K_INC: k_d = k_q + PCW'(1);
      hed_pkg::OP_K_DEC: k_d = k_q - PCW'(1);
      hed_pkg::OP_SIGN: begin
        neg_d = 1'b1;
        k_d   = k_q + PCW'(1);
      end
      hed_pkg::OP_DIGIT: begin
        k_d = k_q + PCW'(1);
        v_d = (acc > (CW+5)'(hed_pkg::CP_LIMIT)) ? hed_pkg::CP_SAT : acc[CW-1:0];
      end
      hed_pkg::OP_PUSH_SEMI: do_push = 1'b1;
      hed_pkg::OP_PUSH_PK: begin
        do_push   = 1'b1;
        push_byte = cur;
        k_d       = k_q - PCW'(1);
      end
      hed_pkg::OP_K_LAST: k_d = pc_q - PCW'(1);
      hed_pkg::OP_K_ZERO: k_d = '0;
      hed_pkg::OP_CLOSE:  pc_d = '0;
      default: ;
    endcase
    for (int i = 0; i < QD; i++) begin
      q_d[i] = q_q[i];
    end
    if (cmd_i.op == hed_pkg::OP_LOAD) begin
      q_d[0] = in_byte_i;
    end else if (do_pop) begin
      for (int i = 0; i < QD - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
      qn_d = qn_q - QNW'(1);
    end else if (do_push) begin
      // prepend; the tail entry falls off when full
      for (int i = 1; i < QD; i++) begin
        q_d[i] = q_q[i-1];
      end
      q_d[0] = push_byte;
      qn_d   = (qn_q == QNW'(QD)) ? qn_q : qn_q + QNW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qn_q      <= '0;
      pc_q      <= '0;
      k_q       <= '0;
      stage_v_q <= 1'b0;
      out_v_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      qn_q   <= qn_d;
      pc_q   <= pc_d;
      k_q    <= k_d;
      last_q <= last_d;
      if (cmd_i.emit) begin
        stage_v_q <= 1'b1;
        if (stage_v_q) begin
          out_v_q <= 1'b1;
        end else if (out_ready_i) begin
          out_v_q <= 1'b0;
        end
      end else if (cmd_i.op == hed_pkg::OP_FLUSH && stage_v_q) begin
        out_v_q   <= 1'b1;
        stage_v_q <= 1'b0;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QD; i++) begin
      q_q[i] <= q_d[i];
    end
    v_q   <= v_d;
    neg_q <= neg_d;
    hex_q <= hex_d;
    if (cmd_i.op == hed_pkg::OP_OPEN) begin
      p_q[0] <= hed_pkg::CH_AMP;
    end else if (cmd_i.op == hed_pkg::OP_APPEND) begin
      p_q[pc_q[IW-1:0]] <= head;
    end
    if (cmd_i.emit) begin
      stage_q <= emit_byte;
      if (stage_v_q) begin
        out_byte_q <= stage_q;
        out_last_q <= 1'b0;
      end
    end else if (cmd_i.op == hed_pkg::OP_FLUSH && stage_v_q) begin
      out_byte_q <= stage_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  assign sts_o.q_empty    = (qn_q == '0);
  assign sts_o.head_amp   = (head == hed_pkg::CH_AMP);
  assign sts_o.head_semi  = (head == hed_pkg::CH_SEMI);
  assign sts_o.last       = last_q;
  assign sts_o.pc_win     = (pc_q == PCW'(DEPTH - 1));
  assign sts_o.name_hit   = hit;
  assign sts_o.num_ok     = (pc_q >= PCW'(2)) && (p_q[1] == hed_pkg::CH_HASH);
  assign sts_o.k_lt_pc    = (k_q < pc_q);
  assign sts_o.k_nx_lt_pc = (k_q < pc_q) && ((k_q + PCW'(1)) < pc_q);
  assign sts_o.k_ge1      = (k_q != '0);
  assign sts_o.hex        = hex_q;
  assign sts_o.cur_ws     = (cur == hed_pkg::CH_SPACE) || (cur >= 8'h09 && cur <= 8'h0D);
  assign sts_o.cur_plus   = (cur == hed_pkg::CH_PLUS);
  assign sts_o.cur_minus  = (cur == hed_pkg::CH_MINUS);
  assign sts_o.cur_zero   = (cur == hed_pkg::CH_ZERO);
  assign sts_o.cur_x      = ((cur | hed_pkg::CASE_BIT) == hed_pkg::CH_X);
  assign sts_o.cur_digit  = dvalid && (hex_q || dval < 4'd10);
  assign sts_o.val_ok     = !neg_q && (v_q != '0) && (v_q <= hed_pkg::CP_LIMIT);
  assign sts_o.utf_last   = utf_last;
  assign sts_o.stage_v    = stage_v_q;
  assign sts_o.out_free   = out_free;

endmodule

@@ src/hed_ctrl.sv @@
// Controller: sequences scanning, decoding, parsing, rescan and flush.
module hed_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hed_pkg::sts_t sts_i,
  output hed_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECODE, S_PWS, S_P0X, S_P0X2, S_PDIG, S_UTF,
    S_FAIL, S_FAIL_K, S_PUSH, S_DUMP, S_END
  } state_e;

  state_e     state_q, state_d;
  logic       ent_q, ent_d, semi_q, semi_d;
  logic [1:0] u_q, u_d;

  always_comb begin
    state_d        = state_q;
    ent_d          = ent_q;
    semi_d         = semi_q;
    u_d            = u_q;
    cmd_o.op       = hed_pkg::OP_NONE;
    cmd_o.emit     = 1'b0;
    cmd_o.emit_sel = hed_pkg::EM_HEAD;
    cmd_o.utf_idx  = u_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = hed_pkg::OP_LOAD;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.q_empty) begin
          if (sts_i.last && ent_q) begin
            cmd_o.op = hed_pkg::OP_K_ZERO;
            state_d  = S_DUMP;
          end else begin
            state_d = S_END;
          end
        end else if (!ent_q) begin
          if (sts_i.head_amp) begin
            cmd_o.op = hed_pkg::OP_OPEN;
            ent_d    = 1'b1;
          end else if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = hed_pkg::EM_HEAD;
            cmd_o.op       = hed_pkg::OP_POP;
          end
        end else if (sts_i.head_semi) begin
          cmd_o.op = hed_pkg::OP_POP;
          state_d  = S_DECODE;
        end else begin
          cmd_o.op = hed_pkg::OP_APPEND;
          if (sts_i.pc_win) begin
            semi_d  = 1'b0;
            state_d = S_FAIL;
          end
        end
      end
      S_DECODE: begin
        if (sts_i.name_hit) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = hed_pkg::EM_NAME;
            cmd_o.op       = hed_pkg::OP_CLOSE;
            ent_d          = 1'b0;
            state_d        = S_SCAN;
          end
        end else if (sts_i.num_ok) begin
          cmd_o.op = hed_pkg::OP_PARSE_INIT;
          state_d  = S_PWS;
        end else begin
          semi_d  = 1'b1;
          state_d = S_FAIL;
        end
      end
      S_PWS: begin
        if (sts_i.k_lt_pc && sts_i.cur_ws) begin
          cmd_o.op = hed_pkg::OP_K_INC;
        end else begin
          if (sts_i.k_lt_pc && sts_i.cur_plus) begin
            cmd_o.op = hed_pkg::OP_K_INC;
          end else if (sts_i.k_lt_pc && sts_i.cur_minus) begin
            cmd_o.op = hed_pkg::OP_SIGN;
          end
          state_d = S_P0X;
        end
      end
      S_P0X: begin
        // look past a leading zero for an x prefix
        if (sts_i.hex && sts_i.k_nx_lt_pc && sts_i.cur_zero) begin
          cmd_o.op = hed_pkg::OP_K_INC;
          state_d  = S_P0X2;
        end else begin
          state_d = S_PDIG;
        end
      end
      S_P0X2: begin
        cmd_o.op = sts_i.cur_x ? hed_pkg::OP_K_INC : hed_pkg::OP_K_DEC;
        state_d  = S_PDIG;
      end
      S_PDIG: begin
        if (sts_i.k_lt_pc && sts_i.cur_digit) begin
          cmd_o.op = hed_pkg::OP_DIGIT;
        end else if (sts_i.val_ok) begin
          u_d     = '0;
          state_d = S_UTF;
        end else begin
          semi_d  = 1'b1;
          state_d = S_FAIL;
        end
      end
      S_UTF: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = hed_pkg::EM_UTF;
          if (u_q == sts_i.utf_last) begin
            cmd_o.op = hed_pkg::OP_CLOSE;
            ent_d    = 1'b0;
            state_d  = S_SCAN;
          end else begin
            u_d = u_q + 2'd1;
          end
        end
      end
      S_FAIL: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = hed_pkg::EM_AMP;
          if (semi_q) begin
            cmd_o.op = hed_pkg::OP_PUSH_SEMI;
          end
          state_d = S_FAIL_K;
        end
      end
      S_FAIL_K: begin
        cmd_o.op = hed_pkg::OP_K_LAST;
        state_d  = S_PUSH;
      end
      S_PUSH: begin
        // push held bytes back in front of the queue, last first
        if (sts_i.k_ge1) begin
          cmd_o.op = hed_pkg::OP_PUSH_PK;
        end else begin
          cmd_o.op = hed_pkg::OP_CLOSE;
          ent_d    = 1'b0;
          state_d  = S_SCAN;
        end
      end
      S_DUMP: begin
        if (sts_i.k_lt_pc) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = hed_pkg::EM_PK;
            cmd_o.op       = hed_pkg::OP_K_INC;
          end
        end else begin
          cmd_o.op = hed_pkg::OP_CLOSE;
          ent_d    = 1'b0;
          state_d  = S_END;
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.op = hed_pkg::OP_FLUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ent_q   <= 1'b0;
      semi_q  <= 1'b0;
      u_q     <= '0;
    end else begin
      state_q <= state_d;
      ent_q   <= ent_d;
      semi_q  <= semi_d;
      u_q     <= u_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ src/html_entity_decoder_top.sv @@
// Top level of the streaming HTML entity decoder.
//
//   port   dir  payload              meaning
//   in_i   in   in_byte, in_last     raw text word, last marks end of text
//   out_o  out  out_byte, out_last   decoded word, last on final decoded word
//
// A word is taken only while the controller is idle; a plain byte passes through
// accept, scan, empty check and hand-off. Each held byte of an entity is appended
// in a scan step; on ';' the body is decoded, a numeric body is parsed byte by byte
// after any prefix steps, and the UTF-8 bytes are emitted in turn. A failed entity
// emits '&' and pushes its held bytes back for rescan, and a flush at the end of
// text dumps the held bytes before the last word. Reset is asynchronous and active
// low; no clearing pass. A stalled output holds the controller in states that emit.
module html_entity_decoder_top #(
  parameter int unsigned WINDOW = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hed_in_if.sink     in_i,
  hed_out_if.source  out_o
);

  hed_pkg::cmd_t cmd;
  hed_pkg::sts_t sts;
  logic          in_ready;

  hed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hed_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (in_i.in_byte),
    .in_last_i   (in_i.in_last),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.out_last)
  );

  assign in_i.ready = in_ready;

  a_stage_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !sts.stage_v)
    else $error("staged word left behind between input words");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("second word taken before the first was processed");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("emit issued while the output register is stalled");

endmodule
